// File: hdl/lstc_pkg.sv
// Shared constants and types for the leading space to tab compressor.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
`default_nettype none
package lstc_pkg;

   // Character codes that the compressor treats specially.
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // Default for the widest tab stop distance that the hardware supports.
   localparam int MAX_STOP_SPAN_DEFAULT = 64;

   // Tab width register: width, reset value and word index.
   localparam int          STOP_SPAN_W     = 7;
   localparam logic [6:0]  STOP_SPAN_RESET = 7'd8;
   localparam int          CSR_ADDR_W      = 3;
   localparam int          CSR_DATA_W      = 32;
   localparam logic        CSR_IDX_STOP_SPAN = 1'b0;

   // Space counts never exceed 255 over the supported range of tab widths.
   localparam int SPACE_CNT_W = 8;

   // Entries in the queue between front end and back end.
   localparam int QUEUE_DEPTH = 2;

   // One command: emit space_count spaces, then char_code with last set.
   typedef struct packed {
      logic [SPACE_CNT_W-1:0] space_count;
      logic [7:0]             char_code;
   } lstc_cmd_type;

endpackage
`default_nettype wire

// File: hdl/lstc_front.sv
// Front end: accepts text bytes, tracks column, pending spaces and text seen.
// Pushes one output command per byte that produces output. Uses lstc_pkg.
`default_nettype none
module lstc_front
   import lstc_pkg::*;
#(
   parameter int MAX_STOP_SPAN = MAX_STOP_SPAN_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [STOP_SPAN_W-1:0] stop_span,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,
   input  wire logic                   queue_full,
   output logic                        cmd_push,
   output lstc_cmd_type                cmd_data
);

   localparam int PW   = $clog2(MAX_STOP_SPAN);
   localparam int WW   = $clog2(MAX_STOP_SPAN + 1);
   localparam int CMPW = (WW > STOP_SPAN_W) ? WW : STOP_SPAN_W;

   logic [PW-1:0] column_ff, column_in;
   logic [PW-1:0] pending_ff, pending_in;
   logic          text_seen_ff, text_seen_in;

   logic [WW-1:0] eff_width;
   logic [WW-1:0] column_ext;
   logic [WW-1:0] column_inc;
   logic [PW-1:0] column_next;
   logic [PW-1:0] pending_inc;
   logic          normalizing;
   logic          wrap;
   logic          accept;

   always_comb begin
      if (stop_span == '0) begin
         eff_width = WW'(1);
      end else if (CMPW'(stop_span) > CMPW'(MAX_STOP_SPAN)) begin
         eff_width = WW'(MAX_STOP_SPAN);
      end else begin
         eff_width = WW'(stop_span);
      end
   end

   // After a width change the column may sit beyond the new width; it is
   // brought back in range by one subtraction per cycle before input resumes.
   assign column_ext  = WW'(column_ff);
   assign normalizing = (column_ext >= eff_width);
   assign req_tready  = !normalizing && !queue_full;
   assign accept      = req_tvalid && req_tready;

   assign column_inc  = column_ext + WW'(1);
   assign wrap        = (column_inc == eff_width);
   assign column_next = wrap ? '0 : PW'(column_inc);
   assign pending_inc = (pending_ff == PW'(MAX_STOP_SPAN - 1)) ?
                        pending_ff : pending_ff + PW'(1);

   always_comb begin
      column_in    = column_ff;
      pending_in   = pending_ff;
      text_seen_in = text_seen_ff;
      cmd_push     = 1'b0;
      cmd_data.space_count = SPACE_CNT_W'(pending_ff);
      cmd_data.char_code   = req_tdata;
      if (normalizing) begin
         column_in = PW'(column_ext - eff_width);
      end else if (accept) begin
         if (req_tdata == CH_SPACE && !text_seen_ff) begin
            column_in = column_next;
            if (wrap) begin
               cmd_push             = 1'b1;
               cmd_data.space_count = '0;
               cmd_data.char_code   = (pending_inc > PW'(1)) ? CH_TAB : CH_SPACE;
               pending_in           = '0;
            end else begin
               pending_in = pending_inc;
            end
         end else if (req_tdata == CH_TAB) begin
            cmd_push             = 1'b1;
            cmd_data.space_count = '0;
            column_in            = '0;
            pending_in           = '0;
         end else if (req_tdata == CH_NEWLINE) begin
            cmd_push     = 1'b1;
            column_in    = '0;
            pending_in   = '0;
            text_seen_in = 1'b0;
         end else begin
            cmd_push     = 1'b1;
            column_in    = column_next;
            pending_in   = '0;
            text_seen_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         pending_ff   <= '0;
         text_seen_ff <= 1'b0;
      end else begin
         column_ff    <= column_in;
         pending_ff   <= pending_in;
         text_seen_ff <= text_seen_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/lstc_queue.sv
// Short command queue between the front end and the back end.
// Register based, first in first out. Uses lstc_pkg.
`default_nettype none
module lstc_queue
   import lstc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  lstc_cmd_type push_data,
   output logic        full,
   input  wire logic   pop,
   output logic        not_empty,
   output lstc_cmd_type head
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   lstc_cmd_type  entry_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: hdl/lstc_back.sv
// Back end: expands each queued command into flushed spaces and a final byte.
// Drives the registered result channel. Uses lstc_pkg.
`default_nettype none
module lstc_back
   import lstc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   cmd_valid,
   input  lstc_cmd_type cmd,
   output logic        cmd_pop,
   output logic        rsp_tvalid,
   input  wire logic   rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   logic [SPACE_CNT_W-1:0] sent_ff, sent_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             data_ff, data_in;
   logic                   last_ff, last_in;
   logic                   load;

   // The output register takes a new byte whenever it is empty or being drained.
   assign load = cmd_valid && (!valid_ff || rsp_tready);

   always_comb begin
      sent_in  = sent_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      cmd_pop  = 1'b0;
      valid_in = valid_ff && !rsp_tready;
      if (load) begin
         valid_in = 1'b1;
         if (sent_ff < cmd.space_count) begin
            data_in = CH_SPACE;
            last_in = 1'b0;
            sent_in = sent_ff + SPACE_CNT_W'(1);
         end else begin
            data_in = cmd.char_code;
            last_in = 1'b1;
            sent_in = '0;
            cmd_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         sent_ff  <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// File: hdl/leading_space_to_tab_compressor_top.sv
// Top level of the leading space to tab compressor: register port and wiring.
// Instantiates lstc_front, lstc_queue and lstc_back; uses lstc_pkg.
`default_nettype none
// One text byte enters per request and one output byte leaves per cycle while
// rsp_tready is high. A byte that causes output is taken every cycle as long
// as the two-entry command queue has room; a leading space that does not reach
// a tab stop produces nothing. A newline or other byte that flushes k held
// spaces makes the output side send those k spaces and then itself, and input
// stalls once the queue fills behind such a burst. Each output byte carries
// tlast on the final byte caused by its input byte. After stop_span is
// written, the held column is reduced into the new width by one subtraction
// per cycle, and no request is taken meanwhile.
module leading_space_to_tab_compressor_top
   import lstc_pkg::*;
#(
   parameter int MAX_STOP_SPAN = MAX_STOP_SPAN_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] in_char
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] out_char
   output logic                       rsp_tlast,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [STOP_SPAN_W-1:0] stop_span_ff, stop_span_in;
   logic                   csr_write;
   logic                   queue_full, queue_not_empty;
   logic                   cmd_push, cmd_pop;
   lstc_cmd_type           cmd_in, cmd_head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      stop_span_in = stop_span_ff;
      if (csr_write && csr_paddr[2] == CSR_IDX_STOP_SPAN) begin
         stop_span_in = csr_pwdata[STOP_SPAN_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_STOP_SPAN) begin
         csr_prdata = CSR_DATA_W'(stop_span_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_span_ff <= STOP_SPAN_RESET;
      end else begin
         stop_span_ff <= stop_span_in;
      end
   end

   lstc_front #(
      .MAX_STOP_SPAN (MAX_STOP_SPAN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .stop_span  (stop_span_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_in)
   );

   lstc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (queue_full),
      .pop       (cmd_pop),
      .not_empty (queue_not_empty),
      .head      (cmd_head)
   );

   lstc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_not_empty),
      .cmd        (cmd_head),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
